// ===== src/hfn_pkg.sv =====
// Shared types and constants for the foot-of-normal Hough voter.
// Used by hfn_foot and the top-level voter; depends on nothing.
`default_nettype none

package hfn_pkg;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int BORDER         = 10;

	localparam int CFG_W = 15;
	localparam int IDX_W = 3;
	localparam int CNT_W = 15;

	// quotient bits of the foot offset divider
	localparam int QB = 11;

	localparam logic [CNT_W-1:0] COUNT_MAX = 15'h7fff;

	typedef logic signed [13:0] coord_t;

	localparam coord_t BORDER_C = coord_t'(BORDER);

	typedef enum logic [1:0] {
		KIND_VOTE  = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH    = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_THRESH   = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_MIN_DIST = 3'd4
	} reg_idx_t;

	localparam logic [9:0]  RST_WIDTH    = 10'd512;
	localparam logic [9:0]  RST_HEIGHT   = 10'd512;
	localparam logic [14:0] RST_THRESH   = 15'd10;
	localparam logic [3:0]  RST_RADIUS   = 4'd2;
	localparam logic [8:0]  RST_MIN_DIST = 9'd0;

	// foot offset from the image middle, per axis
	typedef struct packed {
		logic                ok;
		logic signed [QB:0]  qx;
		logic signed [QB:0]  qy;
	} foot_t;

endpackage

`default_nettype wire

// ===== src/hfn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Self-contained; sized by WIDTH and DEPTH.
`default_nettype none

module hfn_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/hfn_foot.sv =====
// Foot-of-normal offset unit: products, then a bit-serial divider per axis sharing one denominator.
// Depends on hfn_pkg.
`default_nettype none

module hfn_foot (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  hfn_pkg::coord_t      dx,
	input  hfn_pkg::coord_t      dy,
	input  logic signed [15:0]   gx,
	input  logic signed [15:0]   gy,
	output logic                 done,
	output hfn_pkg::foot_t       res
);
	import hfn_pkg::*;

	localparam int PW = 47;
	localparam int DW = 32 + QB - 1;

	typedef enum logic [2:0] {
		F_IDLE, F_MUL, F_SUM, F_PROD, F_ABS, F_DIV, F_OUT
	} fstate_t;

	fstate_t state_q;
	coord_t dx_q, dy_q;
	logic signed [15:0] gx_q, gy_q;
	logic signed [29:0] mx_q, my_q;
	logic signed [31:0] sx_q, sy_q;
	logic signed [30:0] dot_q;
	logic [31:0] nrm_q;
	logic signed [PW-1:0] ex_q, ey_q;
	logic [PW-1:0] remx_q, remy_q, den_q;
	logic negx_q, negy_q;
	logic [QB-1:0] qx_q, qy_q;
	logic [3:0] cnt_q;
	logic gex, gey;

	assign gex = remx_q >= den_q;
	assign gey = remy_q >= den_q;

	// sequence the products and the restoring division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			dx_q <= '0; dy_q <= '0; gx_q <= '0; gy_q <= '0;
			mx_q <= '0; my_q <= '0; sx_q <= '0; sy_q <= '0;
			dot_q <= '0; nrm_q <= '0; ex_q <= '0; ey_q <= '0;
			remx_q <= '0; remy_q <= '0; den_q <= '0;
			negx_q <= 1'b0; negy_q <= 1'b0;
			qx_q <= '0; qy_q <= '0; cnt_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start) begin
						dx_q <= dx; dy_q <= dy; gx_q <= gx; gy_q <= gy;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					mx_q <= 30'(dx_q * gx_q);
					my_q <= 30'(dy_q * gy_q);
					sx_q <= 32'(gx_q * gx_q);
					sy_q <= 32'(gy_q * gy_q);
					state_q <= F_SUM;
				end
				F_SUM: begin
					dot_q <= 31'(mx_q) + 31'(my_q);
					nrm_q <= 32'(sx_q) + 32'(sy_q);
					state_q <= F_PROD;
				end
				F_PROD: begin
					ex_q <= PW'(dot_q * gx_q);
					ey_q <= PW'(dot_q * gy_q);
					state_q <= F_ABS;
				end
				F_ABS: begin
					negx_q <= ex_q[PW-1];
					negy_q <= ey_q[PW-1];
					remx_q <= ex_q[PW-1] ? PW'(-ex_q) : PW'(ex_q);
					remy_q <= ey_q[PW-1] ? PW'(-ey_q) : PW'(ey_q);
					den_q  <= PW'({nrm_q, {(QB-1){1'b0}}});
					qx_q   <= '0;
					qy_q   <= '0;
					cnt_q  <= '0;
					state_q <= F_DIV;
				end
				F_DIV: begin
					if (gex) remx_q <= remx_q - den_q;
					if (gey) remy_q <= remy_q - den_q;
					qx_q  <= {qx_q[QB-2:0], gex};
					qy_q  <= {qy_q[QB-2:0], gey};
					den_q <= den_q >> 1;
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(QB - 1)) state_q <= F_OUT;
				end
				F_OUT: begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// apply signs; a zero gradient has no foot
	assign done   = state_q == F_OUT;
	assign res.ok = nrm_q != '0;
	assign res.qx = negx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
	assign res.qy = negy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});

endmodule

`default_nettype wire

// ===== src/hough_foot_of_normal_vote_and_peak.sv =====
// Hough line voter in foot-of-normal space with peak test. One item is worked
// at a time; the result sits in an output register so the next item can be
// taken while it waits. A vote with its edge flag set passes through the
// product, sum and absolute-value stages and the 11-step serial divider in
// hfn_foot, then one accumulator read-modify-write; a vote without the edge
// flag and an unused kind go straight to the emit step. A peak query reads
// each cell of its clipped window (up to 961) in turn through the single read
// port of the vote store. A clear walks the whole store one cell a cycle, all
// 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) cells. Every item waits in the emit
// step while a stalled earlier result holds the output register. The same
// sweep runs after reset, and no item is taken until it ends (configuration
// writes are taken throughout).
`default_nettype none

module hough_foot_of_normal_vote_and_peak #(
	parameter int MAX_WIDTH  = hfn_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = hfn_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hfn_pkg::IDX_W-1:0] cfg_index,
	input  logic [hfn_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                kind,
	input  logic                      edge_req,
	input  logic [8:0]                pos_x,
	input  logic [8:0]                pos_y,
	input  logic signed [15:0]        grad_x,
	input  logic signed [15:0]        grad_y,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      accepted,
	output logic                      first_vote,
	output logic [8:0]                cell_x,
	output logic [8:0]                cell_y,
	output logic [14:0]               cell_count
);
	import hfn_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = 2 ** AW;
	localparam coord_t MAXW_C = coord_t'(MAX_WIDTH);
	localparam coord_t MAXH_C = coord_t'(MAX_HEIGHT);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_FOOT, S_VRD, S_QCHK, S_QWIN, S_QEND, S_CLR, S_EMIT
	} state_t;

	state_t state_q;
	logic [9:0]  width_q, height_q;
	logic [14:0] thresh_q;
	logic [3:0]  radius_q;
	logic [8:0]  mind_q;

	coord_t px_q, py_q, jx_q, iy_q, x0_q, x1_q, y1_q;
	logic [AW-1:0] addr_q;
	logic [CNT_W-1:0] val_q;
	logic ok_q, pend_q;
	logic res_acc_q, res_first_q;
	logic [8:0] res_x_q, res_y_q;
	logic [CNT_W-1:0] res_cnt_q;
	logic out_valid_q, acc_o_q, first_o_q;
	logic [8:0] x_o_q, y_o_q;
	logic [CNT_W-1:0] cnt_o_q;

	coord_t w_eff, h_eff, cx, cy, px_in, py_in, fx, fy, endx, endy, rad, mind;
	coord_t x0, y0, x1, y1, adx, ady;
	logic f_in, in_rng, okb, win_hit, origin_ok, take, foot_start, foot_done;
	foot_t foot;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [CNT_W-1:0] ram_wdata, ram_rdata, inc;

	// effective image size and middle
	assign w_eff = (coord_t'({4'b0, width_q}) > MAXW_C) ? MAXW_C : coord_t'({4'b0, width_q});
	assign h_eff = (coord_t'({4'b0, height_q}) > MAXH_C) ? MAXH_C : coord_t'({4'b0, height_q});
	assign cx = w_eff >>> 1;
	assign cy = h_eff >>> 1;
	assign px_in = coord_t'({5'b0, pos_x});
	assign py_in = coord_t'({5'b0, pos_y});

	assign in_stall = state_q != S_IDLE;
	assign take = in_valid && !in_stall;
	assign foot_start = take && kind_t'(kind) == KIND_VOTE && edge_req;

	hfn_foot u_foot (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (foot_start),
		.dx     (px_in - cx),
		.dy     (py_in - cy),
		.gx     (grad_x),
		.gy     (grad_y),
		.done   (foot_done),
		.res    (foot)
	);

	// foot point and its range test
	assign fx = cx + coord_t'(foot.qx);
	assign fy = cy + coord_t'(foot.qy);
	assign f_in = fx >= 0 && fx < w_eff - 1 && fy >= 0 && fy < h_eff - 1;

	// peak window limits
	assign endx = w_eff - BORDER_C;
	assign endy = h_eff - BORDER_C;
	assign rad  = coord_t'({10'b0, radius_q});
	assign mind = coord_t'({5'b0, mind_q});
	assign x0 = (px_q - rad < BORDER_C) ? BORDER_C : px_q - rad;
	assign y0 = (py_q - rad < BORDER_C) ? BORDER_C : py_q - rad;
	assign x1 = (px_q + rad + 1 > endx) ? endx : coord_t'(px_q + rad + 1);
	assign y1 = (py_q + rad + 1 > endy) ? endy : coord_t'(py_q + rad + 1);
	assign in_rng = px_q < w_eff && py_q < h_eff;
	assign okb = px_q >= BORDER_C && py_q >= BORDER_C && px_q < endx && py_q < endy
		&& ram_rdata != '0 && ram_rdata >= thresh_q;
	assign win_hit = pend_q && ram_rdata > val_q;
	assign adx = (px_q - cx < 0) ? cx - px_q : px_q - cx;
	assign ady = (py_q - cy < 0) ? cy - py_q : py_q - cy;
	assign origin_ok = adx >= mind || ady >= mind;

	assign inc = (ram_rdata < COUNT_MAX) ? ram_rdata + 1'b1 : ram_rdata;

	// store read address
	always_comb begin
		unique case (state_q)
			S_IDLE:  ram_raddr = {py_in[YW-1:0], px_in[XW-1:0]};
			S_FOOT:  ram_raddr = {fy[YW-1:0], fx[XW-1:0]};
			S_QWIN:  ram_raddr = {iy_q[YW-1:0], jx_q[XW-1:0]};
			default: ram_raddr = '0;
		endcase
	end

	// store write: increment on a vote, zero during a sweep
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		unique case (state_q)
			S_VRD: begin
				ram_we    = 1'b1;
				ram_wdata = inc;
			end
			S_INIT, S_CLR: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	hfn_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			thresh_q <= RST_THRESH;
			radius_q <= RST_RADIUS;
			mind_q   <= RST_MIN_DIST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:    width_q  <= cfg_data[9:0];
				REG_HEIGHT:   height_q <= cfg_data[9:0];
				REG_THRESH:   thresh_q <= cfg_data[14:0];
				REG_RADIUS:   radius_q <= cfg_data[3:0];
				REG_MIN_DIST: mind_q   <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// item sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			px_q <= '0; py_q <= '0; jx_q <= '0; iy_q <= '0;
			x0_q <= '0; x1_q <= '0; y1_q <= '0;
			addr_q <= '0; val_q <= '0; ok_q <= 1'b0; pend_q <= 1'b0;
			res_acc_q <= 1'b0; res_first_q <= 1'b0;
			res_x_q <= '0; res_y_q <= '0; res_cnt_q <= '0;
			out_valid_q <= 1'b0; acc_o_q <= 1'b0; first_o_q <= 1'b0;
			x_o_q <= '0; y_o_q <= '0; cnt_o_q <= '0;
		end else begin
			// load a new result beat, or drop the one just taken
			if (state_q == S_EMIT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT, S_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == '1) begin
						res_acc_q <= 1'b1;
						state_q <= (state_q == S_CLR) ? S_EMIT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						px_q <= px_in;
						py_q <= py_in;
						res_acc_q <= 1'b0;
						res_first_q <= 1'b0;
						res_x_q <= '0;
						res_y_q <= '0;
						res_cnt_q <= '0;
						unique case (kind_t'(kind))
							KIND_VOTE:  state_q <= edge_req ? S_FOOT : S_EMIT;
							KIND_QUERY: begin
								res_x_q <= pos_x;
								res_y_q <= pos_y;
								state_q <= S_QCHK;
							end
							KIND_CLEAR: begin
								addr_q <= '0;
								state_q <= S_CLR;
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_FOOT: begin
					if (foot_done) begin
						if (foot.ok && f_in) begin
							addr_q  <= {fy[YW-1:0], fx[XW-1:0]};
							res_x_q <= fx[8:0];
							res_y_q <= fy[8:0];
							state_q <= S_VRD;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_VRD: begin
					res_acc_q   <= 1'b1;
					res_first_q <= inc == CNT_W'(1);
					res_cnt_q   <= inc;
					state_q     <= S_EMIT;
				end
				S_QCHK: begin
					if (!in_rng) begin
						state_q <= S_EMIT;
					end else begin
						res_cnt_q <= ram_rdata;
						val_q <= ram_rdata;
						if (!okb) begin
							state_q <= S_EMIT;
						end else begin
							jx_q <= x0; iy_q <= y0;
							x0_q <= x0; x1_q <= x1; y1_q <= y1;
							ok_q <= 1'b1;
							pend_q <= 1'b0;
							state_q <= S_QWIN;
						end
					end
				end
				S_QWIN: begin
					pend_q <= 1'b1;
					if (win_hit) ok_q <= 1'b0;
					if (jx_q == x1_q - 1) begin
						jx_q <= x0_q;
						if (iy_q == y1_q - 1) state_q <= S_QEND;
						else iy_q <= coord_t'(iy_q + 1);
					end else begin
						jx_q <= coord_t'(jx_q + 1);
					end
				end
				S_QEND: begin
					res_acc_q <= ok_q && !win_hit && origin_ok;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						acc_o_q   <= res_acc_q;
						first_o_q <= res_first_q;
						x_o_q     <= res_x_q;
						y_o_q     <= res_y_q;
						cnt_o_q   <= res_cnt_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = acc_o_q;
	assign first_vote = first_o_q;
	assign cell_x     = x_o_q;
	assign cell_y     = y_o_q;
	assign cell_count = cnt_o_q;

endmodule

`default_nettype wire

// ===== src/hfn_chk.sv =====
// Port-level checker for the Hough voter, bound to the top level.
// Depends on the top-level port list.
`default_nettype none

module hfn_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      accepted,
	input logic                      first_vote,
	input logic [8:0]                cell_x,
	input logic [8:0]                cell_y,
	input logic [14:0]               cell_count
);

	// hold a stalled result beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(accepted) && $stable(first_vote)
		&& $stable(cell_x) && $stable(cell_y) && $stable(cell_count))
		else $error("stalled result beat changed");

	// one item in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while another is in work");

	// a first vote lands and leaves a count of one
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_vote |-> accepted && cell_count == 15'd1)
		else $error("first vote flag without a count of one");

	// only a clear is accepted with a zero count, and it names no cell
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted && cell_count == 15'd0 |-> cell_x == 9'd0 && cell_y == 9'd0
		&& !first_vote)
		else $error("accepted zero-count result names a cell");

endmodule

bind hough_foot_of_normal_vote_and_peak hfn_chk u_hfn_chk (.*);

`default_nettype wire
